### sv/fisr_pkg.sv
// Shared constants and helpers for the reciprocal square root pipeline.
// Used by fisr_fmul, fisr_fadd and fast_inverse_square_root; depends on nothing.
`default_nettype none
package fisr_pkg;

  localparam logic [31:0] MAGIC        = 32'h5f3759df;
  localparam logic [31:0] ONE_HALF     = 32'h3F000000;
  localparam logic [31:0] THREE_HALVES = 32'h3FC00000;
  localparam logic [31:0] QNAN         = 32'h7FC00000;

  // register stages inside each arithmetic unit
  localparam int MUL_LAT   = 4;
  localparam int ADD_LAT   = 6;
  localparam int Y_DEPTH   = 3 * MUL_LAT + ADD_LAT;
  localparam int TOTAL_LAT = 4 * MUL_LAT + ADD_LAT;

  // leading zero count of a product, 48 when zero
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(47 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // leading zero count of a sum, 28 when zero
  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd28;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 5'(27 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### sv/fast_inverse_square_root.sv
// Top level: magic-constant reciprocal square root estimate and one Newton step.
// Depends on fisr_pkg, fisr_fmul and fisr_fadd.
//
//  channel | dir | signals                 | payload
//  --------+-----+-------------------------+------------------------------------
//  s_axis  | in  | s_tvalid s_tready s_tdata | operand_bits [31:0]
//  m_axis  | out | m_tvalid m_tready m_tdata | recip_root_bits [31:0]
//
// One request enters per cycle while the output is not held; each result passes
// through the chain of four four-stage multipliers and one six-stage adder.
// The whole pipeline advances together; while a result waits untaken at the
// output every stage holds, and s_tready drops until the result is taken.
// Empty slots in the pipeline are carried as bubbles by their valid bits.
// rst clears the valid bits only; data registers carry no reset.
`default_nettype none
module fast_inverse_square_root (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] operand_bits
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata    // [31:0] recip_root_bits
);

  localparam int TL = fisr_pkg::TOTAL_LAT;
  localparam int YD = fisr_pkg::Y_DEPTH;
  localparam int ML = fisr_pkg::MUL_LAT;

  logic          en;
  logic [TL-1:0] vline;
  logic [31:0]   yline [YD];
  logic [31:0]   estimate;
  logic [31:0]   half_x, t1, t2, t3, r;

  // advance whenever the output slot is empty or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vline[TL-1];
  assign m_tdata  = r;

  // initial estimate: constant minus the pattern shifted right arithmetically
  assign estimate = fisr_pkg::MAGIC - {s_tdata[31], s_tdata[31:1]};

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else if (en) begin
      vline <= {vline[TL-2:0], s_tvalid};
    end
  end

  // hold the estimate until each step that needs it
  always_ff @(posedge clk) begin
    if (en) begin
      yline[0] <= estimate;
      for (int i = 1; i < YD; i++) begin
        yline[i] <= yline[i-1];
      end
    end
  end

  // half = 0.5 * x
  fisr_fmul u_half (
    .clk(clk), .en(en), .a(s_tdata), .b(fisr_pkg::ONE_HALF), .y(half_x)
  );

  // t1 = half * y
  fisr_fmul u_t1 (
    .clk(clk), .en(en), .a(half_x), .b(yline[ML-1]), .y(t1)
  );

  // t2 = t1 * y
  fisr_fmul u_t2 (
    .clk(clk), .en(en), .a(t1), .b(yline[2*ML-1]), .y(t2)
  );

  // t3 = 1.5 - t2, as 1.5 plus the negated term
  fisr_fadd u_t3 (
    .clk(clk), .en(en), .a(fisr_pkg::THREE_HALVES), .b({~t2[31], t2[30:0]}), .y(t3)
  );

  // r = y * t3; this unit's last stage is the output register
  fisr_fmul u_r (
    .clk(clk), .en(en), .a(yline[YD-1]), .b(t3), .y(r)
  );

`ifndef SYNTH
  // a NaN result always leaves in canonical quiet form
  a_qnan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0)
      |-> m_tdata == fisr_pkg::QNAN)
    else $error("non-canonical NaN on output");

  // a stalled pipeline drops and invents nothing
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vline))
    else $error("valid bits moved during a stall");

  // nothing is presented straight after reset
  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid just after reset");
`endif

endmodule
`default_nettype wire

### sv/fisr_fmul.sv
// Single-precision multiplier, round to nearest even, gradual underflow, four stages.
// Depends on fisr_pkg; advances all stages together on en.
`default_nettype none
module fisr_fmul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  // stage 1: unpack, classify, mantissa product
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic        sgn, nan, inf;
  logic [23:0] ma, mb;
  logic [7:0]  eae, ebe;
  logic [31:0] spec_val;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    sgn    = a[31] ^ b[31];
    nan    = a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf);
    inf    = a_inf | b_inf;
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    eae    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    ebe    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    if (nan) begin
      spec_val = fisr_pkg::QNAN;
    end else if (inf) begin
      spec_val = {sgn, 8'hFF, 23'd0};
    end else begin
      spec_val = {sgn, 31'd0};
    end
  end

  logic        s1_sign, s1_special;
  logic [31:0] s1_spec;
  logic [47:0] s1_prod;
  logic [8:0]  s1_esum;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign    <= sgn;
      s1_special <= nan | inf | a_zero | b_zero;
      s1_spec    <= spec_val;
      s1_prod    <= ma * mb;
      s1_esum    <= {1'b0, eae} + {1'b0, ebe};
    end
  end

  // stage 2: leading zeros, exponent and shift plan
  logic [5:0]  lz;
  logic [10:0] texp;
  logic        normal, right;
  logic [6:0]  amt;

  always_comb begin
    lz     = fisr_pkg::lzc48(s1_prod);
    texp   = 11'(s1_esum) - 11'd126 - 11'(lz);
    normal = !texp[10] && (texp != 11'd0);
    right  = !normal && (s1_esum < 9'd127);
    if (normal) begin
      amt = 7'(lz);
    end else if (right) begin
      amt = 7'(9'd127 - s1_esum);
    end else begin
      amt = 7'(s1_esum - 9'd127);
    end
  end

  logic        s2_sign, s2_special, s2_normal, s2_right, s2_ovf;
  logic [31:0] s2_spec;
  logic [47:0] s2_prod;
  logic [7:0]  s2_exp;
  logic [6:0]  s2_amt;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign    <= s1_sign;
      s2_special <= s1_special;
      s2_spec    <= s1_spec;
      s2_prod    <= s1_prod;
      s2_normal  <= normal;
      s2_right   <= right;
      s2_ovf     <= normal && (texp >= 11'd255);
      s2_exp     <= texp[7:0];
      s2_amt     <= amt;
    end
  end

  // stage 3: align into the rounding window
  logic [47:0] w;
  logic        lost;

  always_comb begin
    lost = 1'b0;
    if (s2_right) begin
      if (s2_amt >= 7'd48) begin
        w    = 48'd0;
        lost = |s2_prod;
      end else begin
        w    = s2_prod >> s2_amt;
        lost = |(s2_prod & ~({48{1'b1}} << s2_amt));
      end
    end else begin
      w = s2_prod << s2_amt;
    end
  end

  logic        s3_sign, s3_special, s3_ovf, s3_rnd, s3_stk;
  logic [31:0] s3_spec;
  logic [23:0] s3_mant;
  logic [7:0]  s3_exp;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sign    <= s2_sign;
      s3_special <= s2_special;
      s3_spec    <= s2_spec;
      s3_ovf     <= s2_ovf;
      s3_mant    <= w[47:24];
      s3_rnd     <= w[23];
      s3_stk     <= (|w[22:0]) | lost;
      s3_exp     <= s2_normal ? s2_exp : 8'd0;
    end
  end

  // stage 4: round to nearest even and pack; a mantissa carry bumps the exponent
  logic        inc;
  logic [30:0] rounded;

  always_comb begin
    inc     = s3_rnd & (s3_stk | s3_mant[0]);
    rounded = {s3_exp, s3_mant[22:0]} + 31'(inc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3_special) begin
        y <= s3_spec;
      end else if (s3_ovf) begin
        y <= {s3_sign, 8'hFF, 23'd0};
      end else begin
        y <= {s3_sign, rounded};
      end
    end
  end

endmodule
`default_nettype wire

### sv/fisr_fadd.sv
// Single-precision adder, round to nearest even, gradual underflow, six stages.
// Depends on fisr_pkg; advances all stages together on en.
`default_nettype none
module fisr_fadd (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);

  // stage 1: classify, order by magnitude
  logic        a_nan, b_nan, a_inf, b_inf, nan, inf, swap;
  logic [31:0] big, sml, spec_val;
  logic [7:0]  ebig, esml;

  always_comb begin
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    nan   = a_nan | b_nan | (a_inf & b_inf & (a[31] != b[31]));
    inf   = a_inf | b_inf;
    swap  = b[30:0] > a[30:0];
    big   = swap ? b : a;
    sml   = swap ? a : b;
    ebig  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    esml  = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    if (nan) begin
      spec_val = fisr_pkg::QNAN;
    end else begin
      spec_val = {a_inf ? a[31] : b[31], 8'hFF, 23'd0};
    end
  end

  logic        s1_sign, s1_sub, s1_special;
  logic [31:0] s1_spec;
  logic [23:0] s1_mbig, s1_msml;
  logic [7:0]  s1_d, s1_ebig;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign    <= big[31];
      s1_sub     <= a[31] ^ b[31];
      s1_special <= nan | inf;
      s1_spec    <= spec_val;
      s1_mbig    <= {big[30:23] != 8'd0, big[22:0]};
      s1_msml    <= {sml[30:23] != 8'd0, sml[22:0]};
      s1_d       <= ebig - esml;
      s1_ebig    <= ebig;
    end
  end

  // stage 2: align the smaller operand, keep a sticky bit
  logic [26:0] ext, al;

  always_comb begin
    ext = {s1_msml, 3'b000};
    if (s1_d >= 8'd27) begin
      al = {26'd0, |s1_msml};
    end else begin
      al = (ext >> s1_d) | 27'(|(ext & ~({27{1'b1}} << s1_d)));
    end
  end

  logic        s2_sign, s2_sub, s2_special;
  logic [31:0] s2_spec;
  logic [26:0] s2_mb, s2_ms;
  logic [7:0]  s2_ebig;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign    <= s1_sign;
      s2_sub     <= s1_sub;
      s2_special <= s1_special;
      s2_spec    <= s1_spec;
      s2_mb      <= {s1_mbig, 3'b000};
      s2_ms      <= al;
      s2_ebig    <= s1_ebig;
    end
  end

  // stage 3: add or subtract magnitudes
  logic        s3_sign, s3_sub, s3_special;
  logic [31:0] s3_spec;
  logic [27:0] s3_sum;
  logic [7:0]  s3_ebig;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sign    <= s2_sign;
      s3_sub     <= s2_sub;
      s3_special <= s2_special;
      s3_spec    <= s2_spec;
      s3_sum     <= s2_sub ? ({1'b0, s2_mb} - {1'b0, s2_ms}) : ({1'b0, s2_mb} + {1'b0, s2_ms});
      s3_ebig    <= s2_ebig;
    end
  end

  // stage 4: leading zeros and exponent; exact zero is +0 unless both were -0
  logic [4:0] lz;
  logic [9:0] texp;
  logic       normal, zero;

  always_comb begin
    lz     = fisr_pkg::lzc28(s3_sum);
    texp   = 10'(s3_ebig) + 10'd1 - 10'(lz);
    normal = !texp[9] && (texp != 10'd0);
    zero   = (s3_sum == 28'd0);
  end

  logic        s4_sign, s4_special, s4_zero, s4_normal, s4_ovf;
  logic [31:0] s4_spec;
  logic [27:0] s4_sum;
  logic [7:0]  s4_exp;
  logic [4:0]  s4_amt;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sign    <= zero ? (!s3_sub && s3_sign) : s3_sign;
      s4_special <= s3_special;
      s4_spec    <= s3_spec;
      s4_zero    <= zero;
      s4_normal  <= normal;
      s4_ovf     <= normal && (texp >= 10'd255);
      s4_sum     <= s3_sum;
      s4_exp     <= texp[7:0];
      s4_amt     <= normal ? lz : s3_ebig[4:0];
    end
  end

  // stage 5: normalise
  logic [27:0] w;

  always_comb begin
    w = s4_sum << s4_amt;
  end

  logic        s5_sign, s5_special, s5_zero, s5_ovf, s5_rnd, s5_stk;
  logic [31:0] s5_spec;
  logic [23:0] s5_mant;
  logic [7:0]  s5_exp;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_sign    <= s4_sign;
      s5_special <= s4_special;
      s5_spec    <= s4_spec;
      s5_zero    <= s4_zero;
      s5_ovf     <= s4_ovf;
      s5_mant    <= w[27:4];
      s5_rnd     <= w[3];
      s5_stk     <= |w[2:0];
      s5_exp     <= s4_normal ? s4_exp : 8'd0;
    end
  end

  // stage 6: round and pack
  logic        inc;
  logic [30:0] rounded;

  always_comb begin
    inc     = s5_rnd & (s5_stk | s5_mant[0]);
    rounded = {s5_exp, s5_mant[22:0]} + 31'(inc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s5_special) begin
        y <= s5_spec;
      end else if (s5_zero) begin
        y <= {s5_sign, 31'd0};
      end else if (s5_ovf) begin
        y <= {s5_sign, 8'hFF, 23'd0};
      end else begin
        y <= {s5_sign, rounded};
      end
    end
  end

endmodule
`default_nettype wire

### test/fast_inverse_square_root_test.sv
// Testbench for fast_inverse_square_root: drives operand patterns on the input
// stream and checks every result bit-exactly against a single-precision
// predictor or typed-in row. Depends on fisr_pkg and fast_inverse_square_root.
`timescale 1ns / 100ps

module fast_inverse_square_root_test;

  localparam int RANDOM_ITEMS = 1930;
  localparam int SETTLE_CYCLES = fisr_pkg::TOTAL_LAT + 10;

  typedef struct packed {
    logic [31:0] operand;
    logic        known;     // expected result typed in below
    logic [31:0] result;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  // typed-in expectation travelling alongside the request on the bus
  logic        req_known;
  logic [31:0] req_result;

  int sender_idle_pct;
  int sink_stall_pct;
  int failures = 0;
  logic [31:0] pending_roots[$];

  fast_inverse_square_root dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Widen a single-precision pattern to a real; exact for every value.
  function automatic real single_to_real(input logic [31:0] b);
    logic [10:0] dexp;
    logic [22:0] frac;
    logic [23:0] m;
    int          e;
    if (b[30:23] == 8'hFF) begin
      return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'd0});
    end
    if (b[30:23] == 8'h00) begin
      if (b[22:0] == 23'd0) begin
        return $bitstoreal({b[31], 63'd0});
      end
      // renormalise a subnormal
      m = {1'b0, b[22:0]};
      e = -126;
      while (!m[23]) begin
        m = m << 1;
        e--;
      end
      dexp = 11'(e + 1023);
      frac = m[22:0];
      return $bitstoreal({b[31], dexp, frac, 29'd0});
    end
    dexp = 11'(int'(b[30:23]) - 127 + 1023);
    return $bitstoreal({b[31], dexp, b[22:0], 29'd0});
  endfunction

  // Round a real to single precision, nearest even, with gradual underflow.
  // Double carries more than twice the single precision, so rounding an exact
  // or once-rounded double result again gives the correctly rounded single.
  function automatic logic [31:0] real_to_single(input real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] halfway;
    int          e;
    int          shift;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 52'd0) ? fisr_pkg::QNAN : {d[63], 8'hFF, 23'd0};
    end
    if (d[62:52] == 11'h000) begin
      return {d[63], 31'd0};
    end
    e = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    shift = (e >= -126) ? 29 : 29 + (-126 - e);
    if (shift > 60) shift = 60;
    kept = sig >> shift;
    rem = sig & ((64'd1 << shift) - 64'd1);
    halfway = 64'd1 << (shift - 1);
    if (rem > halfway || (rem == halfway && kept[0])) kept = kept + 64'd1;
    if (e < -126) begin
      // subnormal; a carry into bit 23 lands on the smallest normal
      return {d[63], kept[30:0]};
    end
    if (kept[24]) begin
      kept = kept >> 1;
      e++;
    end
    if (e + 127 >= 255) begin
      return {d[63], 8'hFF, 23'd0};
    end
    return {d[63], 8'(e + 127), kept[22:0]};
  endfunction

  function automatic real round_single(input real r);
    return single_to_real(real_to_single(r));
  endfunction

  // Magic-constant estimate refined by one Newton step, single precision.
  function automatic logic [31:0] recip_root(input logic [31:0] xb);
    real         half_x;
    real         y;
    real         t1;
    real         t2;
    real         t3;
    logic [31:0] guess;
    logic [31:0] rb;
    half_x = round_single(0.5 * single_to_real(xb));
    guess = fisr_pkg::MAGIC - {xb[31], xb[31:1]};
    y = single_to_real(guess);
    t1 = round_single(half_x * y);
    t2 = round_single(t1 * y);
    t3 = round_single(single_to_real(fisr_pkg::THREE_HALVES) - t2);
    rb = real_to_single(y * t3);
    if (rb[30:23] == 8'hFF && rb[22:0] != 23'd0) rb = fisr_pkg::QNAN;
    return rb;
  endfunction

  // Operand patterns spread over the classes the step treats differently.
  function automatic logic [31:0] random_operand();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50) begin
      return {1'b0, 8'($urandom_range(8'h4F, 8'h30)), 23'($urandom)};
    end
    if (pick < 70) begin
      return $urandom;
    end
    if (pick < 80) begin
      return {1'($urandom), 8'h00, 23'($urandom)};
    end
    if (pick < 90) begin
      return {1'($urandom), ($urandom_range(1) != 0) ? 8'($urandom_range(8'hFE, 8'hE0))
                                                    : 8'($urandom_range(8'h20, 8'h01)),
              23'($urandom)};
    end
    return {1'($urandom), 8'hFF, ($urandom_range(1) != 0) ? 23'($urandom) : 23'd0};
  endfunction

  // Record every accepted request; typed-in rows bypass the predictor.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      pending_roots.push_back(req_known ? req_result : recip_root(s_tdata));
    end
  end

  // Stall the output at random and check each taken result.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_roots.size() == 0) begin
          $error("recip_root_bits: unexpected result %h", m_tdata);
          failures++;
        end else begin
          if (m_tdata !== pending_roots[0]) begin
            $error("recip_root_bits: expected %h, actual %h", pending_roots[0], m_tdata);
            failures++;
          end
          void'(pending_roots.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Hold the request until the block takes it.
  task automatic send_request(input logic [31:0] operand, input logic known,
                              input logic [31:0] result);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= operand;
    req_known  <= known;
    req_result <= result;
    do @(posedge clk); while (!s_tready);
  endtask

  stim_row_t directed_rows[] = '{
    '{32'h0000_0000, 1'b0, 32'h0},  // +0
    '{32'h8000_0000, 1'b0, 32'h0},  // -0
    '{32'h0000_0001, 1'b0, 32'h0},  // smallest subnormal
    '{32'h007F_FFFF, 1'b0, 32'h0},  // largest subnormal
    '{32'h8040_0000, 1'b0, 32'h0},  // negative subnormal
    '{32'h0080_0000, 1'b0, 32'h0},  // smallest normal
    '{32'h3F80_0000, 1'b0, 32'h0},  // 1.0
    '{32'h4080_0000, 1'b0, 32'h0},  // 4.0
    '{32'h3E80_0000, 1'b0, 32'h0},  // 0.25
    '{32'h7F7F_FFFF, 1'b0, 32'h0},  // largest normal
    '{32'hFF7F_FFFF, 1'b0, 32'h0},  // most negative normal
    '{32'hBF80_0000, 1'b0, 32'h0},  // -1.0, sign dragged into the estimate
    '{32'h7F80_0000, 1'b0, 32'h0},  // +inf
    '{32'hFF80_0000, 1'b0, 32'h0},  // -inf
    '{32'h7FC0_0001, 1'b1, 32'h7FC0_0000},  // quiet NaN, payload dropped
    '{32'h7F80_0001, 1'b1, 32'h7FC0_0000},  // signalling NaN
    '{32'hFFFF_FFFF, 1'b1, 32'h7FC0_0000},  // negative NaN, all ones
    '{32'hBEC0_0000, 1'b0, 32'h0},  // estimate subtraction wraps
    '{32'h5F37_59DF, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b0, 32'h0}
  };

  initial begin
    int idle_plan[3][2];
    idle_plan       = '{'{17, 50}, '{50, 17}, '{0, 0}};
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = 32'd0;
    req_known  = 1'b0;
    req_result = 32'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].operand, directed_rows[i].known, directed_rows[i].result);
    end

    // advance through the idling phases, a third of the random requests each
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_plan[phase][0];
      sink_stall_pct  = idle_plan[phase][1];
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        send_request(random_operand(), 1'b0, 32'd0);
      end
    end
    s_tvalid <= 1'b0;

    // drain, then give any stray result the chance to show itself
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failures == 0 && pending_roots.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Drop the run if the pipeline hangs.
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
sv/fisr_pkg.sv
sv/fisr_fmul.sv
sv/fisr_fadd.sv
sv/fast_inverse_square_root.sv
test/fast_inverse_square_root_test.sv
